// ===== rtl/bdlp_pkg.sv =====
// Shared types and constants of the button debouncer with long-press detection.
// Used by every module of the block; depends on nothing.

package bdlp_pkg;

    // Sizing
    localparam int NUM_BUTTONS = 3;
    localparam int TIME_BITS   = 32;
    localparam int CFG_W       = 16;
    localparam int BTN_W       = 2;
    localparam int KIND_W      = 2;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int ELAPSED_W   = 16;
    localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
    localparam int Q_DEPTH     = NUM_BUTTONS;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = CFG_W'(30);
    localparam logic [CFG_W-1:0] LONG_FIRST_RST = CFG_W'(1000);
    localparam logic [CFG_W-1:0] LONG_SECOND_RST = CFG_W'(1000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SECOND = 2'd2;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_PRESS       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG_FIRST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG_SECOND = 2'd3;

    // One event as held in the event queue
    typedef struct packed {
        logic [BTN_W-1:0]  button;
        logic [KIND_W-1:0] kind;
    } event_t;

    // Push request from the sequencer to the event queue
    typedef struct packed {
        logic   push;
        event_t ev;
    } push_req_t;

    // Queue status back to the sequencer
    typedef struct packed {
        logic empty;
    } queue_stat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_VISIT = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

// ===== rtl/button_debounce_long_press.sv =====
// Top level of the button debouncer with long-press detection: sequencer,
// per-button state and configuration. Depends on bdlp_pkg, bdlp_time_cmp and
// bdlp_event_queue.

// A raw level report never yields an event. A tick is accepted and advances
// the clock, then the buttons (NUM_BUTTONS, here 3) are visited in order
// through a single shared subtract-and-compare unit, then its events are
// delivered while the output is ready, then the sequencer returns to idle.
// in_ready is low from after the tick's transfer until the sequencer is back
// in idle after its last event has been transferred. last_event marks the
// final event of a tick. Configuration writes take effect at once and should
// only be made while in_ready is high.

module button_debounce_long_press (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bdlp_pkg::CMD_W-1:0]       command,
    input  logic [bdlp_pkg::BTN_W-1:0]       button,
    input  logic [bdlp_pkg::ELAPSED_W-1:0]   elapsed_time,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bdlp_pkg::BTN_W-1:0]       event_button,
    output logic [bdlp_pkg::KIND_W-1:0]      event_kind,
    output logic                             last_event,
    input  logic                             cfg_write,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]       cfg_data
);
    import bdlp_pkg::*;

    // Configuration
    logic [CFG_W-1:0]     debounce_reg;
    logic [CFG_W-1:0]     long_first_reg;
    logic [CFG_W-1:0]     long_second_reg;

    // Sequencer
    state_t               state_reg, state_next;
    logic [BTN_IDX_W-1:0] idx_reg, idx_next;

    // Clock and per-button state
    logic [TIME_BITS-1:0]   clock_reg;
    logic [NUM_BUTTONS-1:0] raw_reg;
    logic [NUM_BUTTONS-1:0] stable_reg;
    logic [NUM_BUTTONS-1:0] pending_reg;
    logic [NUM_BUTTONS-1:0] fired_reg;
    logic [TIME_BITS-1:0]   change_time_reg [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   press_time_reg  [NUM_BUTTONS];

    // Visit datapath
    logic                 in_xfer;
    logic                 raw_ok;
    logic [BTN_IDX_W-1:0] raw_idx;
    logic                 mismatch;
    logic                 is_first;
    logic                 is_second;
    logic [TIME_BITS-1:0] cmp_stamp;
    logic [CFG_W-1:0]     cmp_thr;
    logic                 cmp_reached;
    logic                 settle;
    logic                 debounced;
    logic                 long_hit;
    push_req_t            push_req;
    queue_stat_t          q_stat;

    assign in_ready = state_reg == ST_IDLE;
    assign in_xfer  = in_valid && in_ready;
    assign raw_ok   = button < BTN_W'(NUM_BUTTONS);
    assign raw_idx  = button[BTN_IDX_W-1:0];

    // Operand selection for the shared time unit
    assign mismatch  = raw_reg[idx_reg] != stable_reg[idx_reg];
    assign is_first  = idx_reg == BTN_IDX_W'(0);
    assign is_second = idx_reg == BTN_IDX_W'(1);
    assign cmp_stamp = mismatch ? change_time_reg[idx_reg] : press_time_reg[idx_reg];
    assign cmp_thr   = mismatch ? debounce_reg
                                : (is_first ? long_first_reg : long_second_reg);

    bdlp_time_cmp u_time_cmp (
        .now       (clock_reg),
        .stamp     (cmp_stamp),
        .threshold (cmp_thr),
        .reached   (cmp_reached)
    );

    // Per-button decisions for the button being visited
    always_comb
    begin
        settle    = 1'b0;
        debounced = 1'b0;
        long_hit  = 1'b0;
        push_req  = '0;
        push_req.ev.button = BTN_W'(idx_reg);
        if (state_reg == ST_VISIT)
        begin
            if (mismatch)
            begin
                if (!pending_reg[idx_reg])
                begin
                    settle = 1'b1;
                end
                else if (cmp_reached)
                begin
                    debounced = 1'b1;
                    if (raw_reg[idx_reg])
                    begin
                        push_req.push    = 1'b1;
                        push_req.ev.kind = KIND_PRESS;
                    end
                    else if (!fired_reg[idx_reg])
                    begin
                        push_req.push    = 1'b1;
                        push_req.ev.kind = KIND_RELEASE;
                    end
                end
            end
            else if (stable_reg[idx_reg] && !fired_reg[idx_reg]
                     && (is_first || is_second) && cmp_reached)
            begin
                long_hit         = 1'b1;
                push_req.push    = 1'b1;
                push_req.ev.kind = is_first ? KIND_LONG_FIRST : KIND_LONG_SECOND;
            end
        end
    end

    bdlp_event_queue u_event_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_req     (push_req),
        .drain        (state_reg == ST_DRAIN),
        .stat         (q_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_button (event_button),
        .event_kind   (event_kind),
        .last_event   (last_event)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && command == CMD_TICK)
                begin
                    state_next = ST_VISIT;
                    idx_next   = '0;
                end
            end
            ST_VISIT:
            begin
                if (idx_reg == BTN_IDX_W'(NUM_BUTTONS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (q_stat.empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RST;
            long_first_reg  <= LONG_FIRST_RST;
            long_second_reg <= LONG_SECOND_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:    debounce_reg    <= cfg_data;
                CFG_LONG_FIRST:  long_first_reg  <= cfg_data;
                CFG_LONG_SECOND: long_second_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clock and button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= '0;
            raw_reg     <= '0;
            stable_reg  <= '0;
            pending_reg <= '0;
            fired_reg   <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                change_time_reg[i] <= '0;
                press_time_reg[i]  <= '0;
            end
        end
        else
        begin
            // Raw reports and tick transfer
            if (in_xfer)
            begin
                case (command)
                    CMD_TICK:
                    begin
                        clock_reg <= clock_reg
                                     + {{(TIME_BITS-ELAPSED_W){1'b0}}, elapsed_time};
                    end
                    CMD_PRESS, CMD_RELEASE:
                    begin
                        if (raw_ok && (raw_reg[raw_idx] != (command == CMD_PRESS)))
                        begin
                            raw_reg[raw_idx]         <= command == CMD_PRESS;
                            change_time_reg[raw_idx] <= clock_reg;
                            pending_reg[raw_idx]     <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // Visit results
            if (settle)
            begin
                stable_reg[idx_reg] <= raw_reg[idx_reg];
            end
            if (debounced)
            begin
                stable_reg[idx_reg]  <= raw_reg[idx_reg];
                pending_reg[idx_reg] <= 1'b0;
                if (raw_reg[idx_reg])
                begin
                    press_time_reg[idx_reg] <= clock_reg;
                    fired_reg[idx_reg]      <= 1'b0;
                end
            end
            if (long_hit)
            begin
                fired_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Checks
    a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while events are being delivered");

    a_visit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_VISIT |-> idx_reg < BTN_IDX_W'(NUM_BUTTONS))
        else $error("button visit index out of range");

    a_visit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VISIT && idx_reg == BTN_IDX_W'(NUM_BUTTONS - 1))
        |=> state_reg == ST_DRAIN)
        else $error("visit pass did not end after the last button");

    a_push_only_in_visit: assert property (@(posedge clk) disable iff (!rst_n)
        push_req.push |-> (state_reg == ST_VISIT && !out_valid))
        else $error("event pushed outside the visit pass");

endmodule

// ===== rtl/bdlp_time_cmp.sv =====
// Shared elapsed-time unit: wrapping subtract of a time stamp from the clock,
// then compare against a 16-bit threshold. Depends on bdlp_pkg.

module bdlp_time_cmp (
    input  logic [bdlp_pkg::TIME_BITS-1:0] now,
    input  logic [bdlp_pkg::TIME_BITS-1:0] stamp,
    input  logic [bdlp_pkg::CFG_W-1:0]     threshold,
    output logic                           reached
);
    import bdlp_pkg::*;

    logic [TIME_BITS-1:0] diff;

    // Time since stamp, modulo the clock width
    assign diff    = now - stamp;
    assign reached = diff >= {{(TIME_BITS-CFG_W){1'b0}}, threshold};

endmodule

// ===== rtl/bdlp_event_queue.sv =====
// Small event queue: filled while the buttons are visited, then drained on the
// output channel with the final entry flagged. Depends on bdlp_pkg.

module bdlp_event_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bdlp_pkg::push_req_t          push_req,
    input  logic                         drain,
    output bdlp_pkg::queue_stat_t        stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bdlp_pkg::BTN_W-1:0]   event_button,
    output logic [bdlp_pkg::KIND_W-1:0]  event_kind,
    output logic                         last_event
);
    import bdlp_pkg::*;

    event_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 pop;

    // Output side
    assign out_valid    = drain && (count_reg != '0);
    assign pop          = out_valid && out_ready;
    assign event_button = entry_reg[rd_ptr_reg].button;
    assign event_kind   = entry_reg[rd_ptr_reg].kind;
    assign last_event   = count_reg == Q_CNT_W'(1);
    assign stat.empty   = count_reg == '0;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_req.push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        case ({push_req.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_req.push)
        begin
            entry_reg[wr_ptr_reg] <= push_req.ev;
        end
    end

endmodule

// ===== bench/button_debounce_long_press_test.sv =====
// Self-checking testbench for button_debounce_long_press: random and directed
// button traffic, an in-bench prediction of the debounce and long-press events.
// Depends on bdlp_pkg and the button_debounce_long_press RTL.

module button_debounce_long_press_test;

    import bdlp_pkg::*;

    // Codes the package leaves out
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [BTN_W-1:0] NO_BUTTON  = 2'd3;

    // Receiver behavior
    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_PERIOD = 2;
    localparam int HOLD_CYCLES  = 300;

    // Cycles a tick may still be in flight after its last event
    localparam int QUIET_CYCLES = 12;

    typedef struct {
        logic [BTN_W-1:0]  button;
        logic [KIND_W-1:0] kind;
        logic              last;
    } event_rec_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command      = '0;
    logic [BTN_W-1:0]     button       = '0;
    logic [ELAPSED_W-1:0] elapsed_time = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [BTN_W-1:0]     event_button;
    logic [KIND_W-1:0]    event_kind;
    logic                 last_event;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    // Predicted state of the block
    logic [CFG_W-1:0]     debounce_ms;
    logic [CFG_W-1:0]     long_first_ms;
    logic [CFG_W-1:0]     long_second_ms;
    logic [TIME_BITS-1:0] now_ms;
    logic                 raw_lvl     [NUM_BUTTONS];
    logic                 stable_lvl  [NUM_BUTTONS];
    logic                 chg_pending [NUM_BUTTONS];
    logic [TIME_BITS-1:0] chg_ms      [NUM_BUTTONS];
    logic [TIME_BITS-1:0] press_ms    [NUM_BUTTONS];
    logic                 long_done   [NUM_BUTTONS];

    // Elapsed value of the item being predicted
    logic [ELAPSED_W-1:0] elapsed_time_held;

    event_rec_t expected_events [$];

    int  mismatches      = 0;
    int  events_seen     = 0;
    int  effective_items = 0;
    int  hold_requests   = 0;
    int  burst_left      = 0;
    bit  gaps_on         = 1'b1;

    button_debounce_long_press dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .button       (button),
        .elapsed_time (elapsed_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_button (event_button),
        .event_kind   (event_kind),
        .last_event   (last_event),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #4000000;
        $display("button_debounce_long_press_test: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the predicted state by one accepted item and queue its events
    task automatic debounce_predict(input logic [CMD_W-1:0] cmd, input logic [BTN_W-1:0] btn);
        event_rec_t           found [$];
        event_rec_t           rec;
        logic                 lvl;
        logic [TIME_BITS-1:0] since;
        lvl = (cmd == CMD_PRESS);
        if (cmd == CMD_PRESS || cmd == CMD_RELEASE)
        begin
            if (btn < NUM_BUTTONS)
            begin
                if (raw_lvl[btn] != lvl)
                begin
                    raw_lvl[btn]     = lvl;
                    chg_ms[btn]      = now_ms;
                    chg_pending[btn] = 1'b1;
                    effective_items++;
                end
            end
        end
        else if (cmd == CMD_TICK)
        begin
            effective_items++;
            now_ms = now_ms + TIME_BITS'(elapsed_time_held);
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                rec.button = BTN_W'(b);
                rec.last   = 1'b0;
                if (raw_lvl[b] != stable_lvl[b])
                begin
                    since = now_ms - chg_ms[b];
                    if (!chg_pending[b])
                        stable_lvl[b] = raw_lvl[b];
                    else if (since >= TIME_BITS'(debounce_ms))
                    begin
                        stable_lvl[b]  = raw_lvl[b];
                        chg_pending[b] = 1'b0;
                        if (stable_lvl[b])
                        begin
                            press_ms[b]  = now_ms;
                            long_done[b] = 1'b0;
                            rec.kind     = KIND_PRESS;
                            found.push_back(rec);
                        end
                        else if (!long_done[b])
                        begin
                            rec.kind = KIND_RELEASE;
                            found.push_back(rec);
                        end
                    end
                end
                else if (stable_lvl[b] && !long_done[b])
                begin
                    since = now_ms - press_ms[b];
                    // only the first two buttons have a long-press action
                    if (b == 0 && since >= TIME_BITS'(long_first_ms))
                    begin
                        long_done[b] = 1'b1;
                        rec.kind     = KIND_LONG_FIRST;
                        found.push_back(rec);
                    end
                    else if (b == 1 && since >= TIME_BITS'(long_second_ms))
                    begin
                        long_done[b] = 1'b1;
                        rec.kind     = KIND_LONG_SECOND;
                        found.push_back(rec);
                    end
                end
            end
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                expected_events.push_back(found[i]);
        end
    endtask

    // One input transfer, then a random gap at the end of a burst
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BTN_W-1:0] btn,
                             input logic [ELAPSED_W-1:0] ms);
        in_valid     <= 1'b1;
        command      <= cmd;
        button       <= btn;
        elapsed_time <= ms;
        do
            @(posedge clk);
        while (!in_ready);
        elapsed_time_held = ms;
        debounce_predict(cmd, btn);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(0, 7);
            end
            else
                burst_left--;
        end
    endtask

    // Stop sending and let every expected event arrive
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back while the block is idle
    task automatic load_settings(input logic [CFG_W-1:0] deb_ms,
                                 input logic [CFG_W-1:0] first_ms,
                                 input logic [CFG_W-1:0] second_ms);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= deb_ms;
        @(posedge clk);
        cfg_index <= CFG_LONG_FIRST;
        cfg_data  <= first_ms;
        @(posedge clk);
        cfg_index <= CFG_LONG_SECOND;
        cfg_data  <= second_ms;
        @(posedge clk);
        cfg_write      <= 1'b0;
        debounce_ms    = deb_ms;
        long_first_ms  = first_ms;
        long_second_ms = second_ms;
    endtask

    function automatic logic [ELAPSED_W-1:0] clamp_ms(input int v);
        return (v > 65535) ? '1 : ELAPSED_W'(v);
    endfunction

    function automatic logic [ELAPSED_W-1:0] any_ms();
        return ELAPSED_W'($urandom_range(0, 65535));
    endfunction

    // Shorter than the debounce window
    function automatic logic [ELAPSED_W-1:0] short_ms();
        return (debounce_ms == 0) ? '0 : ELAPSED_W'($urandom_range(0, int'(debounce_ms) - 1));
    endfunction

    // Enough to settle a pending change, often right on the boundary
    function automatic logic [ELAPSED_W-1:0] settle_ms();
        int v;
        v = int'(debounce_ms) + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        return clamp_ms(v);
    endfunction

    // A slice of a hold, sometimes the full long-press time
    function automatic logic [ELAPSED_W-1:0] hold_ms();
        int v;
        int limit;
        limit = (long_first_ms > long_second_ms) ? int'(long_first_ms) : int'(long_second_ms);
        case ($urandom_range(0, 3))
            0:       v = int'(long_first_ms);
            1:       v = int'(long_second_ms);
            default: v = $urandom_range(0, limit / 2 + 5);
        endcase
        return clamp_ms(v);
    endfunction

    // One press-hold-release gesture with bounce, or a piece of noise
    task automatic random_gesture();
        logic [BTN_W-1:0] main_btn;
        logic [BTN_W-1:0] other_btn;
        bit               two;
        int               pick;
        pick      = $urandom_range(0, 99);
        main_btn  = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
        other_btn = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
        two       = ($urandom_range(0, 2) == 0);
        if (pick < 16)
            send_item(CMD_W'($urandom_range(0, 3)), BTN_W'($urandom_range(0, 3)), any_ms());
        else if (pick < 22)
        begin
            // broken gesture: a lone level change and a short tick
            send_item(($urandom_range(0, 1) == 0) ? CMD_PRESS : CMD_RELEASE, main_btn, any_ms());
            send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)), short_ms());
        end
        else if (pick < 24)
            wait_quiet();
        else
        begin
            send_item(CMD_PRESS, main_btn, any_ms());
            if (two)
                send_item(CMD_PRESS, other_btn, any_ms());
            // contact bounce inside the window
            repeat ($urandom_range(0, 2))
            begin
                send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)), short_ms());
                send_item(CMD_RELEASE, main_btn, any_ms());
                send_item(CMD_PRESS, main_btn, any_ms());
            end
            send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)), settle_ms());
            repeat ($urandom_range(0, 3))
                send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)), hold_ms());
            send_item(CMD_RELEASE, main_btn, any_ms());
            if (two && $urandom_range(0, 3) != 0)
                send_item(CMD_RELEASE, other_btn, any_ms());
            send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)),
                      ($urandom_range(0, 4) == 0) ? short_ms() : settle_ms());
        end
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] deb_ms,
                                input logic [CFG_W-1:0] first_ms,
                                input logic [CFG_W-1:0] second_ms,
                                input int count);
        int start;
        load_settings(deb_ms, first_ms, second_ms);
        start = effective_items;
        while (effective_items - start < count)
            random_gesture();
    endtask

    // Reset settings: three presses in one tick, both long presses, release rules
    task automatic test_reset_settings();
        for (int b = 0; b < NUM_BUTTONS; b++)
            send_item(CMD_PRESS, BTN_W'(b), '0);
        send_item(CMD_TICK, '0, 16'd29);
        send_item(CMD_TICK, '0, 16'd1);
        send_item(CMD_TICK, '0, 16'd999);
        send_item(CMD_TICK, '0, 16'd0);
        send_item(CMD_TICK, '0, 16'd1);
        send_item(CMD_RELEASE, 2'd0, '0);
        send_item(CMD_RELEASE, 2'd2, '1);
        send_item(CMD_TICK, '0, '1);
    endtask

    // Unused command, bad button, repeated level, bounce restarting the window
    task automatic test_odd_commands();
        send_item(CMD_UNUSED, NO_BUTTON, '1);
        send_item(CMD_PRESS, NO_BUTTON, '0);
        send_item(CMD_RELEASE, NO_BUTTON, '1);
        send_item(CMD_PRESS, 2'd0, '0);
        send_item(CMD_TICK, NO_BUTTON, 16'd20);
        send_item(CMD_PRESS, 2'd0, '0);
        send_item(CMD_TICK, '0, 16'd10);
        send_item(CMD_RELEASE, 2'd0, '0);
        send_item(CMD_TICK, '0, 16'd20);
        send_item(CMD_PRESS, 2'd0, '0);
        send_item(CMD_RELEASE, 2'd0, '0);
        send_item(CMD_TICK, '0, 16'd20);
        send_item(CMD_TICK, '0, 16'd10);
    endtask

    // Zero times: settle and long press on back-to-back zero ticks
    task automatic test_zero_settings();
        load_settings('0, '0, '0);
        send_item(CMD_PRESS, 2'd0, '0);
        send_item(CMD_PRESS, 2'd2, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_RELEASE, 2'd1, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_RELEASE, 2'd0, '0);
        send_item(CMD_TICK, '0, '1);
    endtask

    // Receiver holds off while the sender keeps offering event-heavy ticks
    task automatic test_backpressure();
        load_settings(16'd5, 16'd20, 16'd20);
        hold_requests <= hold_requests + 1;
        repeat (3)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
                send_item(CMD_PRESS, BTN_W'(b), '0);
            send_item(CMD_TICK, '0, 16'd5);
            send_item(CMD_TICK, '0, 16'd20);
            for (int b = 0; b < NUM_BUTTONS; b++)
                send_item(CMD_RELEASE, BTN_W'(b), '0);
            send_item(CMD_TICK, '0, 16'd5);
        end
        // sender waits for every event before going on
        wait_quiet();
        send_item(CMD_PRESS, 2'd1, '0);
        send_item(CMD_TICK, '0, 16'd5);
    endtask

    // Largest tick steps back to back, with a press and a long press across them
    task automatic test_long_ticks();
        load_settings(16'd100, 16'd500, 16'd500);
        for (int b = 0; b < NUM_BUTTONS; b++)
            send_item(CMD_RELEASE, BTN_W'(b), '0);
        send_item(CMD_TICK, '0, '1);
        wait_quiet();
        gaps_on = 1'b0;
        send_item(CMD_TICK, '0, '1);
        send_item(CMD_PRESS, 2'd0, '0);
        send_item(CMD_PRESS, 2'd1, '0);
        send_item(CMD_TICK, '0, 16'd150);
        send_item(CMD_TICK, '0, 16'd600);
        send_item(CMD_TICK, '0, '1);
        gaps_on = 1'b1;
        send_item(CMD_RELEASE, 2'd0, '0);
        send_item(CMD_RELEASE, 2'd1, '0);
        send_item(CMD_TICK, '0, '1);
    endtask

    // Random gestures under several settings, extremes included
    task automatic test_random();
        int events_start;
        events_start = events_seen;
        random_phase(DEBOUNCE_RST, LONG_FIRST_RST, LONG_SECOND_RST, 50);
        random_phase('0, '0, '0, 50);
        random_phase('1, '1, '1, 50);
        random_phase(16'd7, 16'd40, 16'd90, 50);
        random_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 400)),
                     CFG_W'($urandom_range(0, 400)), 50);
        while (events_seen - events_start < 48)
            random_gesture();
    endtask

    // Receiver: its own ready pattern, plus a long hold-off on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int beat;
        int hold_left;
        int hold_seen;
        mode      = READY_ALWAYS;
        mode_left = 0;
        beat      = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(READY_ALWAYS, READY_PERIOD);
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            beat++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
                    default:      out_ready <= ((beat % 5) >= 2);
                endcase
            end
        end
    end

    // Compare each event transfer with the oldest prediction
    always @(posedge clk)
    begin : check_events
        event_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            events_seen++;
            if (expected_events.size() == 0)
                report_mismatch("unexpected event, button", int'(event_button), -1);
            else
            begin
                want = expected_events.pop_front();
                if (event_button !== want.button)
                    report_mismatch("event_button", int'(event_button), int'(want.button));
                if (event_kind !== want.kind)
                    report_mismatch("event_kind", int'(event_kind), int'(want.kind));
                if (last_event !== want.last)
                    report_mismatch("last_event", int'(last_event), int'(want.last));
            end
        end
    end

    initial
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            raw_lvl[b]     = 1'b0;
            stable_lvl[b]  = 1'b0;
            chg_pending[b] = 1'b0;
            chg_ms[b]      = '0;
            press_ms[b]    = '0;
            long_done[b]   = 1'b0;
        end
        now_ms            = '0;
        debounce_ms       = DEBOUNCE_RST;
        long_first_ms     = LONG_FIRST_RST;
        long_second_ms    = LONG_SECOND_RST;
        elapsed_time_held = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_odd_commands();
        test_zero_settings();
        test_backpressure();
        test_long_ticks();
        test_random();

        wait_quiet();
        if (mismatches == 0)
            $display("button_debounce_long_press_test: PASS");
        else
            $display("button_debounce_long_press_test: FAIL");
        $finish;
    end

endmodule
